@@ rtl/core/pm_carrier_pll_demod_macros.svh @@
// Assertion macros for the PM carrier PLL demodulator checker
`ifndef PM_CARRIER_PLL_DEMOD_MACROS_SVH
`define PM_CARRIER_PLL_DEMOD_MACROS_SVH
`define PMD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("label failed");
`define PMD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("label failed");
`endif

@@ rtl/core/pmd_pkg.sv @@
// Shared types, constants and CORDIC table for the PM carrier PLL demodulator
`default_nettype none
package pmd_pkg;
  localparam int SampleBits = 16;
  localparam int PhaseBits = 16;
  localparam int CordicStages = 24;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 17;
  localparam logic [CfgIdxBits-1:0] CfgPhaseGain = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgFreqGain = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgFreqLimit = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgSubStep = 2'd3;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;

  typedef enum logic [2:0] {
    StIdle, StTrig, StAngle, StMix, StMixOut, StLoop, StOut
  } back_state_e;

  function automatic logic [31:0] atan_tab(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/pmd_front.sv @@
// Input stage: accept sample words into a two-entry queue
`default_nettype none
module pmd_front #(
  parameter int SampleBits = pmd_pkg::SampleBits
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [SampleBits-1:0]   in_i_i,
  input  wire logic [SampleBits-1:0]   in_q_i,
  output logic                         q_valid_o,
  input  wire logic                    q_ready_i,
  output logic [SampleBits-1:0]        q_i_o,
  output logic [SampleBits-1:0]        q_q_o
);
  logic [SampleBits-1:0] i_q [2];
  logic [SampleBits-1:0] qd_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign q_i_o = i_q[rd_q];
  assign q_q_o = qd_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      i_q[wr_q] <= in_i_i;
      qd_q[wr_q] <= in_q_i;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/pmd_cordic.sv @@
// Iterative CORDIC unit, rotation or vectoring, one stage per cycle
`default_nettype none
module pmd_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               vec_i,
  input  wire logic signed [33:0] x_i,
  input  wire logic signed [33:0] y_i,
  input  wire logic signed [33:0] z_i,
  output logic                    done_o,
  output logic signed [33:0]      x_o,
  output logic signed [33:0]      y_o,
  output logic signed [33:0]      z_o
);
  logic signed [33:0] x_q, y_q, z_q;
  logic [4:0] k_q;
  logic busy_q, vec_q, done_q;
  logic dir;
  logic signed [33:0] dx, dy, at;

  assign dir = vec_q ? ~y_q[33] : ~z_q[33];
  assign dx = y_q >>> k_q;
  assign dy = x_q >>> k_q;
  assign at = $signed({2'b00, pmd_pkg::atan_tab(k_q)});
  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q <= '0;
      vec_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q <= '0;
        vec_q <= vec_i;
      end else if (busy_q) begin
        k_q <= k_q + 5'd1;
        if (k_q == 5'(pmd_pkg::CordicStages - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (busy_q) begin
      if (vec_q ? dir : dir) begin
        if (vec_q) begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
        end else begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
        end
      end else begin
        if (vec_q) begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/pmd_back.sv @@
// Loop engine: trig, mixing, phase detector and loop filter for one word
`default_nettype none
module pmd_back #(
  parameter int SampleBits = pmd_pkg::SampleBits,
  parameter int PhaseBits = pmd_pkg::PhaseBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  output logic                       q_ready_o,
  input  wire logic [SampleBits-1:0] q_i_i,
  input  wire logic [SampleBits-1:0] q_q_i,
  input  wire logic [16:0]           phase_gain_i,
  input  wire logic [16:0]           freq_gain_i,
  input  wire logic [14:0]           freq_limit_i,
  input  wire logic [15:0]           sub_step_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [SampleBits-1:0]      out_re_o,
  output logic [SampleBits-1:0]      out_im_o
);
  localparam int Pb = PhaseBits;
  localparam int Sb = SampleBits;
  localparam int PMax = (1 << (Pb - 1)) - 1;
  localparam logic signed [Sb+1:0] SHi = (Sb+2)'((1 << (Sb - 1)) - 1);
  localparam logic signed [Sb+1:0] SLo = -SHi - (Sb+2)'(1);

  pmd_pkg::back_state_e st_q, st_d;
  logic [Pb-1:0] pc_q, sp_q, ang_q;
  logic signed [Pb-1:0] fr_q;
  logic signed [Sb-1:0] si_q, sq_q, m_q;
  logic signed [15:0] cc_q, cs_q, sc_q, ss_q;
  logic [1:0] tsel_q;
  logic signed [Sb-1:0] re_q, im_q;
  logic signed [47:0] p0_q, p1_q;
  logic signed [Pb-1:0] err_q;

  logic c_start, c_vec, c_done;
  logic signed [33:0] c_xi, c_yi, c_zi, c_xo, c_yo, c_zo;
  logic [31:0] ta;
  logic tflip;
  logic signed [33:0] vx, vy;
  logic [31:0] vz;
  logic [Pb-1:0] trig_ph;

  pmd_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(c_start), .vec_i(c_vec), .x_i(c_xi), .y_i(c_yi),
    .z_i(c_zi), .done_o(c_done), .x_o(c_xo), .y_o(c_yo), .z_o(c_zo)
  );

  function automatic logic signed [15:0] rnd_sat(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) return 16'sh7fff;
    if (r < -34'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  function automatic logic signed [Sb-1:0] sat_s(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = v >>> 15;
    if (r > 48'(SHi)) return SHi[Sb-1:0];
    if (r < 48'(SLo)) return SLo[Sb-1:0];
    return r[Sb-1:0];
  endfunction

  assign trig_ph = (st_q == pmd_pkg::StIdle) ? pc_q : sp_q;
  always_comb begin
    ta = {trig_ph, {(32 - Pb){1'b0}}};
    tflip = (ta >= 32'h4000_0000) && (ta < 32'hC000_0000);
    if (tflip) ta = ta - 32'h8000_0000;
    vx = 34'(si_q) <<< (30 - Sb);
    vy = 34'(sq_q) <<< (30 - Sb);
    vz = 32'd0;
    if (vx[33]) begin
      vx = -vx;
      vy = -vy;
      vz = 32'h8000_0000;
    end
  end

  logic tflip_q;
  always_ff @(posedge clk_i) begin
    if (c_start) tflip_q <= tflip;
  end

  logic [31:0] zsum;
  logic signed [Pb+18:0] ep, ef;
  logic signed [Pb+1:0] lim, frn;
  logic signed [Pb+1:0] fsum;
  assign zsum = c_zo[31:0] + 32'(1 << (31 - Pb));
  assign ep = (Pb+19)'(err_q) * $signed({2'b00, phase_gain_i});
  assign ef = (Pb+19)'(err_q) * $signed({2'b00, freq_gain_i});
  always_comb begin
    lim = (freq_limit_i > 15'(PMax)) ? (Pb+2)'(PMax) : (Pb+2)'(freq_limit_i);
    fsum = (Pb+2)'(fr_q) + (Pb+2)'(ef >>> 16);
    frn = fsum;
    if (fsum > lim) frn = lim;
    if (fsum < -lim) frn = -lim;
  end

  assign q_ready_o = (st_q == pmd_pkg::StIdle);
  assign out_valid_o = (st_q == pmd_pkg::StOut);
  assign out_re_o = re_q;
  assign out_im_o = im_q;

  always_comb begin
    st_d = st_q;
    c_start = 1'b0;
    c_vec = 1'b0;
    c_xi = pmd_pkg::CordicGainQ30;
    c_yi = '0;
    c_zi = 34'($signed(ta));
    unique case (st_q)
      pmd_pkg::StIdle: if (q_valid_i) begin
        st_d = pmd_pkg::StTrig;
        c_start = 1'b1;
      end
      pmd_pkg::StTrig: if (c_done) begin
        if (tsel_q == 2'd0) begin
          c_start = 1'b1;
        end else begin
          st_d = pmd_pkg::StAngle;
          c_start = 1'b1;
          c_vec = 1'b1;
          c_xi = vx;
          c_yi = vy;
          c_zi = {2'b00, vz};
        end
      end
      pmd_pkg::StAngle: if (c_done) st_d = pmd_pkg::StMix;
      pmd_pkg::StMix: st_d = pmd_pkg::StMixOut;
      pmd_pkg::StMixOut: st_d = pmd_pkg::StLoop;
      pmd_pkg::StLoop: st_d = pmd_pkg::StOut;
      pmd_pkg::StOut: if (out_ready_i) st_d = pmd_pkg::StIdle;
      default: st_d = pmd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pmd_pkg::StIdle;
      tsel_q <= 2'd0;
      pc_q <= '0;
      sp_q <= '0;
      fr_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == pmd_pkg::StIdle && q_valid_i) tsel_q <= 2'd0;
      if (st_q == pmd_pkg::StTrig && c_done) tsel_q <= tsel_q + 2'd1;
      if (st_q == pmd_pkg::StLoop) begin
        sp_q <= sp_q + Pb'($signed(sub_step_i));
        fr_q <= frn[Pb-1:0];
        pc_q <= pc_q + Pb'(ep >>> 16) + frn[Pb-1:0];
      end
    end
  end

  logic signed [15:0] fc, fs;
  assign fc = rnd_sat(tflip_q ? -c_xo : c_xo);
  assign fs = rnd_sat(tflip_q ? -c_yo : c_yo);

  always_ff @(posedge clk_i) begin
    if (st_q == pmd_pkg::StIdle && q_valid_i) begin
      si_q <= q_i_i;
      sq_q <= q_q_i;
    end
    if (st_q == pmd_pkg::StTrig && c_done) begin
      if (tsel_q == 2'd0) begin
        cc_q <= fc; cs_q <= fs;
      end else begin
        sc_q <= fc; ss_q <= fs;
      end
    end
    if (st_q == pmd_pkg::StAngle && c_done) begin
      ang_q <= (si_q == '0 && sq_q == '0) ? '0 : zsum[31 -: Pb];
      p0_q <= 48'(sq_q) * 48'(cc_q);
      p1_q <= 48'(si_q) * 48'(cs_q);
    end
    if (st_q == pmd_pkg::StMix) begin
      m_q <= sat_s(p0_q - p1_q);
      err_q <= ang_q - pc_q;
    end
    if (st_q == pmd_pkg::StMixOut) begin
      p0_q <= 48'(m_q) * 48'(sc_q);
      p1_q <= -(48'(m_q) * 48'(ss_q));
    end
    if (st_q == pmd_pkg::StLoop) begin
      re_q <= sat_s(p0_q);
      im_q <= sat_s(p1_q);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/pm_carrier_pll_demod.sv @@
// Top level of the PM carrier PLL demodulator with subcarrier mixer
// One I/Q word gives one mixed output word. For each word the loop engine runs one shared
// iterative CORDIC of 24 stages in turn on the carrier trig, the subcarrier trig and the
// phase detector, then steps through the mixing and loop update states (StMix, StMixOut,
// StLoop), an output state and the idle state; it takes a new word only when idle. A stalled
// output holds the engine. The input queue holds two words so the source may run ahead of
// the loop engine.
`default_nettype none
module pm_carrier_pll_demod #(
  parameter int SampleBits = pmd_pkg::SampleBits,
  parameter int PhaseBits = pmd_pkg::PhaseBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // in_i, in_q
  input  wire logic [((2*SampleBits+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // out_re, out_im
  output logic [((2*SampleBits+7)/8)*8-1:0]       m_axis_tdata,
  input  wire logic                               cfg_we_i,
  input  wire logic [pmd_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  wire logic [pmd_pkg::CfgDataBits-1:0]    cfg_data_i
);
  localparam int TdW = ((2 * SampleBits + 7) / 8) * 8;
  logic [16:0] pg_q, fg_q;
  logic [14:0] fl_q;
  logic [15:0] ss_q;
  logic qv, qr;
  logic [SampleBits-1:0] qi, qq, ore, oim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_q <= '0; fg_q <= '0; fl_q <= 15'h7fff; ss_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmd_pkg::CfgPhaseGain: pg_q <= cfg_data_i;
        pmd_pkg::CfgFreqGain: fg_q <= cfg_data_i;
        pmd_pkg::CfgFreqLimit: fl_q <= cfg_data_i[14:0];
        pmd_pkg::CfgSubStep: ss_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  pmd_front #(.SampleBits(SampleBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_i_i(s_axis_tdata[SampleBits-1:0]), .in_q_i(s_axis_tdata[2*SampleBits-1:SampleBits]),
    .q_valid_o(qv), .q_ready_i(qr), .q_i_o(qi), .q_q_o(qq)
  );

  pmd_back #(.SampleBits(SampleBits), .PhaseBits(PhaseBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_i_i(qi), .q_q_i(qq),
    .phase_gain_i(pg_q), .freq_gain_i(fg_q), .freq_limit_i(fl_q), .sub_step_i(ss_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_re_o(ore), .out_im_o(oim)
  );

  assign m_axis_tdata = TdW'({oim, ore});
endmodule
`default_nettype wire

@@ rtl/core/pmd_checker.sv @@
// Port-level checker for the PM carrier PLL demodulator
`include "pm_carrier_pll_demod_macros.svh"
`default_nettype none
module pmd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);
  `PMD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `PMD_ASSERT_NXT(a_out_gap, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
  `PMD_ASSERT_NXT(a_in_ready_hold, clk_i, rst_ni, s_axis_tready && !s_axis_tvalid, s_axis_tready)
endmodule
bind pm_carrier_pll_demod pmd_checker u_pmd_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);
`default_nettype wire

@@ tb/tb_pm_carrier_pll_demod.sv @@
// Self-checking testbench for the PM carrier PLL demodulator with subcarrier mixer
`default_nettype none
module tb_pm_carrier_pll_demod;
  timeunit 1ns;
  timeprecision 1ps;
  import pmd_pkg::*;

  localparam int DataW = 32;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic signed [15:0] q;
    logic signed [15:0] i;
  } iq_t;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } mix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  pm_carrier_pll_demod i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // loop state and registers
  logic [16:0] alpha_q, beta_q;
  logic [14:0] flim_q;
  logic [15:0] step_q;
  logic [15:0] pc_q, fr_q, sp_q;

  iq_t  pending_q[$];
  mix_t mix_expected_q[$];
  int   fails = 0;
  int   idle_cycles = 0;
  bit   hold_src = 1'b0;
  int   src_gap = 0, snk_gap = 0;

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clamp16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic void sin_cos(logic [15:0] ph, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy;
    a = {ph, 16'h0};
    flip = 0;
    x = 652032874;
    y = 0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1;
    end
    z = longint'($signed(a));
    for (int k = 0; k < CordicStages; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_tab(k[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_tab(k[4:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp16(floor_shift(x + 16384, 15));
    s = clamp16(floor_shift(y + 16384, 15));
  endfunction

  function automatic logic [15:0] phase_of(longint si, longint sq);
    longint x, y, dx, dy;
    logic [31:0] z;
    if (si == 0 && sq == 0) return 16'h0;
    x = si <<< 14;
    y = sq <<< 14;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int k = 0; k < CordicStages; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab(k[4:0]);
      end else begin
        x -= dx; y += dy; z -= atan_tab(k[4:0]);
      end
    end
    z += 32'h8000;
    return z[31:16];
  endfunction

  function automatic void demod_step(iq_t w);
    longint cc, cs, sc, ss, m, err, fr, lim, si, sq;
    logic [15:0] ang, d;
    mix_t r;
    si = w.i;
    sq = w.q;
    sin_cos(pc_q, cc, cs);
    sin_cos(sp_q, sc, ss);
    m = clamp16(floor_shift(sq * cc - si * cs, 15));
    r.re = 16'(clamp16(floor_shift(m * sc, 15)));
    r.im = 16'(clamp16(floor_shift(-(m * ss), 15)));
    mix_expected_q.push_back(r);
    sp_q = sp_q + step_q;
    ang = phase_of(si, sq);
    d = ang - pc_q;
    err = longint'($signed(d));
    lim = flim_q;
    fr = longint'($signed(fr_q)) + floor_shift(err * longint'(beta_q), 16);
    if (fr > lim) fr = lim;
    if (fr < -lim) fr = -lim;
    fr_q = fr[15:0];
    pc_q = pc_q + 16'(floor_shift(err * longint'(alpha_q), 16)) + fr[15:0];
  endfunction

  function automatic void model_write(logic [CfgIdxBits-1:0] idx, logic [16:0] v);
    case (idx)
      CfgPhaseGain: alpha_q = v;
      CfgFreqGain:  beta_q = v;
      CfgFreqLimit: flim_q = v[14:0];
      CfgSubStep:   step_q = v[15:0];
      default: ;
    endcase
  endfunction

  initial forever #5 clk_i = ~clk_i;

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      demod_step(iq_t'(s_axis_tdata));
    end
    if (s_axis_tvalid && !s_axis_tready) begin
    end else if (src_gap > 0 || hold_src || pending_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
      if (src_gap > 0) src_gap <= src_gap - 1;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= pending_q.pop_front();
      src_gap <= ($urandom_range(0, 3) == 0) ? 0 :
                 (($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                 : $urandom_range(0, 4));
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mix_t got, exp_w;
    if (m_axis_tvalid && m_axis_tready) begin
      got = mix_t'(m_axis_tdata);
      if (mix_expected_q.size() == 0) begin
        $error("unexpected word re=%0d im=%0d", got.re, got.im);
        fails++;
      end else begin
        exp_w = mix_expected_q.pop_front();
        if (got.re !== exp_w.re) begin
          $error("out_re expected %0d actual %0d", exp_w.re, got.re);
          fails++;
        end
        if (got.im !== exp_w.im) begin
          $error("out_im expected %0d actual %0d", exp_w.im, got.im);
          fails++;
        end
      end
    end
    if (snk_gap > 0) begin
      m_axis_tready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      snk_gap <= ($urandom_range(0, 2) == 0) ? 0 :
                 (($urandom_range(0, 24) == 0) ? $urandom_range(30, 200)
                                                 : $urandom_range(0, 3));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[pm_carrier_pll_demod] ERROR");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  task automatic reg_write(logic [CfgIdxBits-1:0] idx, logic [16:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    model_write(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    wait (!s_axis_tvalid && mix_expected_q.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic iq_t random_sample();
    iq_t w;
    int r;
    r = $urandom_range(0, 9);
    w.i = 16'($urandom);
    w.q = 16'($urandom);
    if (r == 0) begin
      w.i = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    end else if (r == 1) begin
      w.q = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    end else if (r == 2) begin
      w.i = 16'($signed(16'($urandom_range(0, 15))) - 8);
      w.q = 16'($signed(16'($urandom_range(0, 15))) - 8);
    end
    return w;
  endfunction

  task automatic phase_run(int n, logic [16:0] a, logic [16:0] b, logic [16:0] lim,
                           logic [16:0] st, bit tone);
    iq_t w;
    logic [15:0] ph;
    longint c, s;
    reg_write(CfgPhaseGain, a);
    reg_write(CfgFreqGain, b);
    reg_write(CfgFreqLimit, lim);
    reg_write(CfgSubStep, st);
    ph = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      if (tone && $urandom_range(0, 4) != 0) begin
        // offset carrier: rotating phasor with some noise
        ph = ph + 16'd700 + 16'($urandom_range(0, 400));
        sin_cos(ph, c, s);
        w.i = 16'(c - 1000 + $urandom_range(0, 2000));
        w.q = 16'(s - 1000 + $urandom_range(0, 2000));
      end else begin
        w = random_sample();
      end
      pending_q.push_back(w);
    end
    drain();
  endtask

  initial begin
    alpha_q = 0; beta_q = 0; flim_q = 15'h7fff; step_q = 0;
    pc_q = 0; fr_q = 0; sp_q = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: corners with default loop gains, then a pause for everything to drain
    pending_q.push_back('{q: 16'sh0, i: 16'sh0});
    pending_q.push_back('{q: 16'sh7fff, i: 16'sh7fff});
    pending_q.push_back('{q: 16'sh8000, i: 16'sh8000});
    pending_q.push_back('{q: 16'sh7fff, i: 16'sh8000});
    pending_q.push_back('{q: 16'sh8000, i: 16'sh7fff});
    pending_q.push_back('{q: 16'sh0, i: 16'sh8000});
    pending_q.push_back('{q: 16'sh0, i: 16'sh7fff});
    pending_q.push_back('{q: 16'sh8000, i: 16'sh0});
    pending_q.push_back('{q: 16'sh7fff, i: 16'sh0});
    pending_q.push_back('{q: -16'sh1, i: -16'sh1});
    pending_q.push_back('{q: 16'sh5555, i: -16'sh5556});
    pending_q.push_back('{q: -16'sh5556, i: 16'sh5555});
    hold_src = 1'b1;
    repeat (3) @(posedge clk_i);
    hold_src = 1'b0;
    drain();

    reg_write(CfgPhaseGain, 17'h1ffff);
    reg_write(CfgFreqGain, 17'h1ffff);
    reg_write(CfgFreqLimit, 17'h7fff);
    reg_write(CfgSubStep, 17'h08000);
    for (int k = 0; k < 12; k++) pending_q.push_back(random_sample());
    pending_q.push_back('{q: 16'sh0, i: 16'sh0});
    drain();

    phase_run(110, 17'd4000, 17'd300, 17'd2000, 17'h0f00, 1'b1);
    phase_run(100, 17'd65536, 17'd65536, 17'd0, 17'h18000, 1'b0);
    phase_run(110, 17'd131071, 17'd131071, 17'd32767, 17'h07fff, 1'b0);
    phase_run(110, 17'd12000, 17'd900, 17'd500, 17'h1f000, 1'b1);
    phase_run(100, 17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom), 1'b1);

    drain();
    if (fails == 0) begin
      $display("[pm_carrier_pll_demod] OK");
    end else begin
      $display("[pm_carrier_pll_demod] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
